FILE: src/p2c_pkg.sv
// shared types, constants and functions for the polar to cartesian converter
package p2c_pkg;

  localparam int RANGE_W = 24;
  localparam int BEARING_W = 19;
  localparam int FLOOR_W = 25;
  localparam int COORD_WIDTH_DEF = 25;
  localparam int CORDIC_STAGES_DEF = 18;

  localparam int XW = 44;
  localparam int ZW = 34;
  localparam int GAIN_W = 32;
  localparam int PROD_W = RANGE_W + GAIN_W;
  localparam int FRAC_SHIFT = 16;
  localparam int ANGLE_SHIFT = 14;
  localparam int FIN_W = 50;

  localparam logic [GAIN_W-1:0] GAIN_INF = 32'd2608131496;
  localparam logic [GAIN_W-1:0] GAIN_TAIL = 32'd1738754331;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] ANG_PI = 34'sd3373259426;
  localparam logic signed [XW-1:0] ROUND_HALF = 44'sd32768;
  localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = 25'sd7;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic neg;
  } p2c_vec_t;

  // gain for a finite number of rotations
  function automatic logic [GAIN_W-1:0] cordic_gain(input int n);
    logic [GAIN_W-1:0] g;
    g = GAIN_INF;
    if (2 * n < 32) begin
      g = g + (GAIN_TAIL >> (2 * n));
    end
    return g;
  endfunction

  // atan(2^-i) in q.30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 34'sd843314857;
      1: a = 34'sd497837829;
      2: a = 34'sd263043837;
      3: a = 34'sd133525159;
      4: a = 34'sd67021687;
      5: a = 34'sd33543516;
      6: a = 34'sd16775851;
      7: a = 34'sd8388437;
      8: a = 34'sd4194283;
      9: a = 34'sd2097149;
      10: a = 34'sd1048576;
      default: begin
        if (i <= 30) begin
          a = 34'sd1 <<< (30 - i);
        end else begin
          a = '0;
        end
      end
    endcase
    return a;
  endfunction

endpackage

FILE: src/p2c_ifs.sv
// channel interfaces: polar input, cartesian output, floor configuration
interface p2c_in_if;
  logic valid;
  logic ready;
  logic [p2c_pkg::RANGE_W-1:0] range_in;
  logic signed [p2c_pkg::BEARING_W-1:0] bearing;
  modport source (output valid, range_in, bearing, input ready);
  modport sink (input valid, range_in, bearing, output ready);
endinterface

interface p2c_out_if #(
  parameter int W = p2c_pkg::COORD_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [W-1:0] x_coord;
  logic signed [W-1:0] y_coord;
  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

interface p2c_cfg_if;
  logic valid;
  logic ready;
  logic signed [p2c_pkg::FLOOR_W-1:0] coordinate_floor;
  modport source (output valid, coordinate_floor, input ready);
  modport sink (input valid, coordinate_floor, output ready);
endinterface

FILE: src/p2c_prep.sv
// first stage: quadrant fold of the bearing and gain-scaled initial vector
module p2c_prep #(
  parameter int CORDIC_STAGES = p2c_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                v_in,
  input  logic [p2c_pkg::RANGE_W-1:0]         range_in,
  input  logic signed [p2c_pkg::BEARING_W-1:0] bearing,
  output logic                                v_out,
  output p2c_pkg::p2c_vec_t                   d_out
);

  localparam logic [p2c_pkg::GAIN_W-1:0] GAIN = p2c_pkg::cordic_gain(CORDIC_STAGES);

  logic [p2c_pkg::PROD_W-1:0] prod;
  logic signed [p2c_pkg::ZW-1:0] z_raw;
  p2c_pkg::p2c_vec_t d_next;

  always_comb begin
    prod = p2c_pkg::PROD_W'(range_in) * p2c_pkg::PROD_W'(GAIN);
    z_raw = {{(p2c_pkg::ZW - p2c_pkg::BEARING_W - p2c_pkg::ANGLE_SHIFT){bearing[p2c_pkg::BEARING_W-1]}},
             bearing, {p2c_pkg::ANGLE_SHIFT{1'b0}}};
    d_next.x = {{(p2c_pkg::XW - p2c_pkg::PROD_W + p2c_pkg::FRAC_SHIFT){1'b0}},
                prod[p2c_pkg::PROD_W-1:p2c_pkg::FRAC_SHIFT]};
    d_next.y = '0;
    if (z_raw > p2c_pkg::ANG_HALF_PI) begin
      d_next.z = z_raw - p2c_pkg::ANG_PI;
      d_next.neg = 1'b1;
    end else if (z_raw < -p2c_pkg::ANG_HALF_PI) begin
      d_next.z = z_raw + p2c_pkg::ANG_PI;
      d_next.neg = 1'b1;
    end else begin
      d_next.z = z_raw;
      d_next.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: src/p2c_cordic_stage.sv
// one registered cordic rotation step
module p2c_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  p2c_pkg::p2c_vec_t d_in,
  output logic              v_out,
  output p2c_pkg::p2c_vec_t d_out
);

  localparam logic signed [p2c_pkg::ZW-1:0] ATAN = p2c_pkg::atan_q30(STAGE);

  logic signed [p2c_pkg::XW-1:0] dx;
  logic signed [p2c_pkg::XW-1:0] dy;
  p2c_pkg::p2c_vec_t d_next;

  always_comb begin
    dx = d_in.y >>> STAGE;
    dy = d_in.x >>> STAGE;
    d_next.neg = d_in.neg;
    if (!d_in.z[p2c_pkg::ZW-1]) begin
      d_next.x = d_in.x - dx;
      d_next.y = d_in.y + dy;
      d_next.z = d_in.z - ATAN;
    end else begin
      d_next.x = d_in.x + dx;
      d_next.y = d_in.y - dy;
      d_next.z = d_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: src/p2c_finish.sv
// rounding to q8.16 and sign fold, registered, then floor and saturation
module p2c_finish #(
  parameter int COORD_WIDTH = p2c_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               v_in,
  input  p2c_pkg::p2c_vec_t                  d_in,
  input  logic signed [p2c_pkg::FLOOR_W-1:0] coord_floor,
  output logic                               v_out,
  output logic signed [COORD_WIDTH-1:0]      x_coord,
  output logic signed [COORD_WIDTH-1:0]      y_coord
);

  localparam logic signed [p2c_pkg::FIN_W-1:0] HI =
    {{(p2c_pkg::FIN_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [p2c_pkg::FIN_W-1:0] LO = ~HI;

  logic signed [p2c_pkg::XW-1:0] xr;
  logic signed [p2c_pkg::XW-1:0] yr;
  logic signed [p2c_pkg::FIN_W-1:0] xs;
  logic signed [p2c_pkg::FIN_W-1:0] ys;
  logic signed [p2c_pkg::FIN_W-1:0] xa_next;
  logic signed [p2c_pkg::FIN_W-1:0] ya_next;
  logic signed [p2c_pkg::FIN_W-1:0] xa;
  logic signed [p2c_pkg::FIN_W-1:0] ya;
  logic signed [p2c_pkg::FIN_W-1:0] floor_ext;
  logic signed [p2c_pkg::FIN_W-1:0] xf;
  logic signed [p2c_pkg::FIN_W-1:0] yf;
  logic signed [p2c_pkg::FIN_W-1:0] xsat;
  logic signed [p2c_pkg::FIN_W-1:0] ysat;

  always_comb begin
    xr = d_in.x + p2c_pkg::ROUND_HALF;
    yr = d_in.y + p2c_pkg::ROUND_HALF;
    xs = p2c_pkg::FIN_W'(xr >>> p2c_pkg::FRAC_SHIFT);
    ys = p2c_pkg::FIN_W'(yr >>> p2c_pkg::FRAC_SHIFT);
    xa_next = d_in.neg ? -xs : xs;
    ya_next = d_in.neg ? -ys : ys;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa <= xa_next;
      ya <= ya_next;
    end
  end

  always_comb begin
    floor_ext = p2c_pkg::FIN_W'(coord_floor);
    xf = (xa < floor_ext) ? floor_ext : xa;
    yf = (ya < floor_ext) ? floor_ext : ya;
    xsat = (xf > HI) ? HI : ((xf < LO) ? LO : xf);
    ysat = (yf > HI) ? HI : ((yf < LO) ? LO : yf);
    x_coord = COORD_WIDTH'(xsat);
    y_coord = COORD_WIDTH'(ysat);
  end

endmodule

FILE: src/p2c_skid.sv
// output register with one skid entry; pipeline enable comes from its fill
module p2c_skid #(
  parameter int COORD_WIDTH = p2c_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic                          en,
  p2c_out_if.source                     cart
);

  logic out_valid;
  logic skid_valid;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] skid_x;
  logic signed [COORD_WIDTH-1:0] skid_y;
  logic pop;
  logic load;

  assign pop = out_valid & cart.ready;
  assign load = ~out_valid | pop;
  assign en = ~skid_valid;

  assign cart.valid = out_valid;
  assign cart.x_coord = out_x;
  assign cart.y_coord = out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      out_valid <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (skid_valid) begin
        out_x <= skid_x;
        out_y <= skid_y;
      end else begin
        out_x <= x_coord;
        out_y <= y_coord;
      end
    end
    if (push && !(load && !skid_valid)) begin
      skid_x <= x_coord;
      skid_y <= y_coord;
    end
  end

endmodule

FILE: src/polar_to_cartesian_floor.sv
// top level: pipelined cordic polar to cartesian converter with coordinate floor
// One transaction enters per clock while the pipeline is not held; its x/y result passes
// through one fold/multiply stage, one register per cordic rotation, one rounding stage
// and the output register. The whole pipeline holds while the output register and its
// skid entry are both full, so polar.ready depends only on registered state. cfg is always
// ready. Write the floor register via cfg only while idle; the block does not enforce it.
module polar_to_cartesian_floor #(
  parameter int COORD_WIDTH = p2c_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = p2c_pkg::CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  p2c_in_if.sink    polar,
  p2c_out_if.source cart,
  p2c_cfg_if.sink   cfg
);

  logic en;
  logic signed [p2c_pkg::FLOOR_W-1:0] coord_floor;
  logic stage_v [0:CORDIC_STAGES];
  p2c_pkg::p2c_vec_t stage_d [0:CORDIC_STAGES];
  logic fin_v;
  logic signed [COORD_WIDTH-1:0] fin_x;
  logic signed [COORD_WIDTH-1:0] fin_y;

  assign polar.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_floor <= p2c_pkg::FLOOR_RESET;
    end else if (cfg.valid) begin
      coord_floor <= cfg.coordinate_floor;
    end
  end

  p2c_prep #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (polar.valid),
    .range_in (polar.range_in),
    .bearing  (polar.bearing),
    .v_out    (stage_v[0]),
    .d_out    (stage_d[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    p2c_cordic_stage #(
      .STAGE(g)
    ) u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (stage_v[g]),
      .d_in  (stage_d[g]),
      .v_out (stage_v[g+1]),
      .d_out (stage_d[g+1])
    );
  end

  p2c_finish #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_finish (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .v_in        (stage_v[CORDIC_STAGES]),
    .d_in        (stage_d[CORDIC_STAGES]),
    .coord_floor (coord_floor),
    .v_out       (fin_v),
    .x_coord     (fin_x),
    .y_coord     (fin_y)
  );

  p2c_skid #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_skid (
    .clk     (clk),
    .rst     (rst),
    .push    (en & fin_v),
    .x_coord (fin_x),
    .y_coord (fin_y),
    .en      (en),
    .cart    (cart)
  );

endmodule
